### rtl/hamming_encode_correct_assert.svh
// Assertion macros shared by the Hamming encoder and corrector.
`ifndef HAMMING_ENCODE_CORRECT_ASSERT_SVH
`define HAMMING_ENCODE_CORRECT_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset
`define HEC_ASSERT_NOW(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("hamming check failed");

// Next-cycle implication, checked on every rising clock edge outside reset
`define HEC_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("hamming check failed");

`endif

### rtl/hec_pkg.sv
// Package with widths, constants and bit-layout functions of the Hamming codec.
`default_nettype none

package hec_pkg;

   localparam int MAX_PARITY = 6;
   localparam int CODE_W     = 63;
   localparam int DATA_W     = CODE_W - MAX_PARITY;
   localparam int LEN_W      = 6;
   localparam int NP_W       = 3;
   localparam int RESET_LEN  = 4;

   typedef enum logic {
      OP_ENCODE  = 1'b0,
      OP_CORRECT = 1'b1
   } opcode_type;

   // Number of parity bits needed for nd data bits
   function automatic logic [NP_W-1:0] hec_parity_count(input logic [LEN_W-1:0] nd);
      logic [NP_W-1:0] np;
      np = NP_W'(MAX_PARITY);
      for (int p = MAX_PARITY; p >= 2; p--) begin
         if (((1 << p) - p - 1) >= int'(nd)) begin
            np = NP_W'(p);
         end
      end
      return np;
   endfunction

   // Spread data bits over the positions that are not powers of two
   function automatic logic [CODE_W-1:0] hec_scatter(input logic [DATA_W-1:0] data);
      logic [CODE_W-1:0] w;
      int i;
      w = '0;
      i = 0;
      for (int p = 1; p <= CODE_W; p++) begin
         if ((p & (p - 1)) != 0) begin
            w[p-1] = data[i];
            i++;
         end
      end
      return w;
   endfunction

   // Positions covered by parity bit k (position number has bit k set)
   function automatic logic [CODE_W-1:0] hec_cover_mask(input int k);
      logic [CODE_W-1:0] m;
      m = '0;
      for (int p = 1; p <= CODE_W; p++) begin
         if (((p >> k) & 1) != 0) begin
            m[p-1] = 1'b1;
         end
      end
      return m;
   endfunction

endpackage

`default_nettype wire

### rtl/hamming_encode_correct.sv
// Pipelined Hamming single-error-correcting encoder and checker.
//
// Input channel req_*: one item per handshake. req_tuser is the opcode
// (0 encode req_tdata data word, 1 check and correct the received word).
// Result channel rsp_*: one result item per input item, in order, carrying
// the codeword, code length, parity count, syndrome and bad-position flag.
// csr_wr_en / csr_wr_data set the data length (1 to 57, 0 acts as 1,
// larger values act as 57); write it only while no item is in flight.
//
// Three register stages: layout and masking, syndrome XOR trees, then
// parity insert or single-bit correction into the output register.
// An accepted item passes the stage 1 and stage 2 registers into the output
// register, which drives rsp_tvalid; one item enters every cycle unless held.
// When the receiver holds rsp_tready low with the output register full the
// whole pipeline holds and req_tready follows rsp_tready.
// Synchronous reset empties the pipeline and sets the data length to 4.
`default_nettype none

module hamming_encode_correct (
   input  wire                clock,
   input  wire                reset,
   input  wire                csr_wr_en,
   input  wire [hec_pkg::LEN_W-1:0] csr_wr_data,  // data_length
   input  wire                req_tvalid,
   output logic               req_tready,
   input  wire [119:0]        req_tdata,   // data_word[56:0], received_word[119:57]
   input  wire                req_tuser,   // opcode
   output logic               rsp_tvalid,
   input  wire                rsp_tready,
   output logic [79:0]        rsp_tdata    // code_word[62:0], code_length[68:63],
                                           // parity_count[71:69], syndrome[77:72],
                                           // bad_position[78], zero[79]
);
   import hec_pkg::*;
   `include "hamming_encode_correct_assert.svh"

   // configuration
   logic [LEN_W-1:0] data_length_ff;

   // stage 1: layout
   logic              s1_valid_ff, s1_valid_in;
   opcode_type        s1_op_ff, s1_op_in;
   logic [CODE_W-1:0] s1_word_ff, s1_word_in;
   logic [LEN_W-1:0]  s1_nh_ff, s1_nh_in;
   logic [NP_W-1:0]   s1_np_ff, s1_np_in;

   // stage 2: syndrome
   logic              s2_valid_ff;
   opcode_type        s2_op_ff;
   logic [CODE_W-1:0] s2_word_ff;
   logic [LEN_W-1:0]  s2_nh_ff;
   logic [NP_W-1:0]   s2_np_ff;
   logic [LEN_W-1:0]  s2_syn_ff, s2_syn_in;

   // stage 3: output register
   logic              out_valid_ff;
   logic [CODE_W-1:0] out_word_ff, out_word_in;
   logic [LEN_W-1:0]  out_nh_ff;
   logic [NP_W-1:0]   out_np_ff;
   logic [LEN_W-1:0]  out_syn_ff, out_syn_in;
   logic              out_bad_ff, out_bad_in;

   logic              advance;
   logic [LEN_W-1:0]  used_len;
   logic [DATA_W-1:0] data_masked;
   logic [CODE_W-1:0] recv_masked;
   logic [CODE_W-1:0] flip_vec;
   logic [CODE_W-1:0] parity_vec;

   // pipeline moves whenever the output register is free or being taken
   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = advance;

   // hold the data length register
   always_ff @(posedge clock) begin
      if (reset) begin
         data_length_ff <= LEN_W'(RESET_LEN);
      end else if (csr_wr_en) begin
         data_length_ff <= csr_wr_data;
      end
   end

   // stage 1: clamp length, size the code, mask and place the bits
   always_comb begin
      if (data_length_ff == '0) begin
         used_len = LEN_W'(1);
      end else if (data_length_ff > LEN_W'(DATA_W)) begin
         used_len = LEN_W'(DATA_W);
      end else begin
         used_len = data_length_ff;
      end
      s1_np_in    = hec_parity_count(used_len);
      s1_nh_in    = used_len + LEN_W'(s1_np_in);
      data_masked = req_tdata[DATA_W-1:0] & ~({DATA_W{1'b1}} << used_len);
      recv_masked = req_tdata[119:DATA_W] & ~({CODE_W{1'b1}} << s1_nh_in);
      s1_op_in    = opcode_type'(req_tuser);
      s1_valid_in = req_tvalid;
      if (s1_op_in == OP_CORRECT) begin
         s1_word_in = recv_masked;
      end else begin
         s1_word_in = hec_scatter(data_masked);
      end
   end

   // stage 2: parity checks over each covered position set
   always_comb begin
      for (int k = 0; k < MAX_PARITY; k++) begin
         s2_syn_in[k] = ^(s1_word_ff & hec_cover_mask(k));
      end
   end

   // stage 3: insert parity bits or correct the named bit
   always_comb begin
      parity_vec = '0;
      for (int k = 0; k < MAX_PARITY; k++) begin
         parity_vec[(1 << k) - 1] = s2_syn_ff[k];
      end
      flip_vec = CODE_W'((64'(1) << s2_syn_ff) >> 1);
      unique case (s2_op_ff)
         OP_ENCODE: begin
            out_word_in = s2_word_ff | parity_vec;
            out_syn_in  = '0;
            out_bad_in  = 1'b0;
         end
         OP_CORRECT: begin
            out_syn_in = s2_syn_ff;
            out_bad_in = s2_syn_ff > s2_nh_ff;
            if (out_bad_in) begin
               out_word_in = s2_word_ff;
            end else begin
               out_word_in = s2_word_ff ^ flip_vec;
            end
         end
         default: begin
            out_word_in = s2_word_ff;
            out_syn_in  = '0;
            out_bad_in  = 1'b0;
         end
      endcase
   end

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s1_valid_ff;
         out_valid_ff <= s2_valid_ff;
      end
   end

   // advance payload
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_op_ff    <= s1_op_in;
         s1_word_ff  <= s1_word_in;
         s1_nh_ff    <= s1_nh_in;
         s1_np_ff    <= s1_np_in;
         s2_op_ff    <= s1_op_ff;
         s2_word_ff  <= s1_word_ff;
         s2_nh_ff    <= s1_nh_ff;
         s2_np_ff    <= s1_np_ff;
         s2_syn_ff   <= s2_syn_in;
         out_word_ff <= out_word_in;
         out_nh_ff   <= s2_nh_ff;
         out_np_ff   <= s2_np_ff;
         out_syn_ff  <= out_syn_in;
         out_bad_ff  <= out_bad_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_bad_ff, out_syn_ff, out_np_ff, out_nh_ff, out_word_ff};

   // an accepted item always reaches stage 1
   `HEC_ASSERT_NEXT(a_accept_enters, clock, reset, req_tvalid && req_tready, s1_valid_ff)
   // a bad position flag only comes with a syndrome past the code end
   `HEC_ASSERT_NOW(a_bad_past_end, clock, reset, rsp_tvalid && out_bad_ff,
                   out_syn_ff > out_nh_ff)
   // no codeword bit beyond the code length
   `HEC_ASSERT_NOW(a_word_in_range, clock, reset, rsp_tvalid,
                   (out_word_ff >> out_nh_ff) == '0)

endmodule

`default_nettype wire

### tb/sv/tb_hamming_encode_correct.sv
// Self-checking testbench for the Hamming encoder and single-error corrector.
`timescale 1ns / 100ps

module tb_hamming_encode_correct;
   import hec_pkg::*;

   // Result item as carried on rsp_tdata, lowest field last
   typedef struct packed {
      logic        spare;
      logic        bad_position;
      logic [5:0]  syndrome;
      logic [2:0]  parity_count;
      logic [5:0]  code_length;
      logic [62:0] code_word;
   } codec_result_type;

   // One row of the directed table
   typedef struct packed {
      logic [5:0]       len;
      opcode_type       op;
      logic [56:0]      data;
      logic [62:0]      rcv;
      logic             typed;
      codec_result_type want;
   } stim_row_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          csr_wr_en = 1'b0;
   logic [5:0]    csr_wr_data = '0;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [119:0]  req_tdata = '0;   // data_word[56:0], received_word[119:57]
   logic          req_tuser = 1'b0; // opcode
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [79:0]   rsp_tdata;        // code_word[62:0], code_length[68:63],
                                    // parity_count[71:69], syndrome[77:72],
                                    // bad_position[78], zero[79]

   codec_result_type pending[$];
   stim_row_type     vectors[$];
   logic [5:0]       data_len = 6'd4;
   int               mismatch_count = 0;
   bit               sender_quiet = 1'b0;

   hamming_encode_correct i_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Encode or check one word for the given data length register value
   function automatic codec_result_type hamming_result(input logic [5:0] len_reg,
                                                       input opcode_type op,
                                                       input logic [56:0] data,
                                                       input logic [62:0] rcv);
      codec_result_type r;
      logic [62:0]      word;
      logic [62:0]      mask;
      logic             par;
      int               nd, nh, np, pos, i, syn;
      nd = int'(len_reg);
      if (nd < 1) nd = 1;
      if (nd > 57) nd = 57;
      // place data bits, skipping power-of-two positions
      word = '0;
      pos = 0;
      i = 0;
      while (i < nd) begin
         pos++;
         if ((pos & (pos - 1)) != 0) begin
            word[pos-1] = data[i];
            i++;
         end
      end
      nh = pos;
      np = nh - nd;
      mask = (nh >= 63) ? '1 : ((63'(1) << nh) - 63'(1));
      if (op == OP_CORRECT) word = rcv & mask;
      syn = 0;
      for (int k = 0; k < np; k++) begin
         par = 1'b0;
         for (int p = 1; p <= nh; p++) begin
            if (((p >> k) & 1) != 0) par ^= word[p-1];
         end
         if (op == OP_ENCODE) word[(1 << k) - 1] = par;
         else syn |= int'(par) << k;
      end
      r = '0;
      if (op == OP_CORRECT) begin
         if (syn > nh) r.bad_position = 1'b1;
         else if (syn != 0) word[syn-1] = ~word[syn-1];
      end
      r.code_word    = word & mask;
      r.code_length  = 6'(nh);
      r.parity_count = 3'(np);
      r.syndrome     = 6'(syn);
      return r;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic void add_vector(input logic [5:0] len, input opcode_type op,
                                      input logic [56:0] data, input logic [62:0] rcv,
                                      input logic typed, input logic [62:0] cw,
                                      input logic [5:0] clen, input logic [2:0] np,
                                      input logic [5:0] syn, input logic bad);
      stim_row_type row;
      row.len  = len;
      row.op   = op;
      row.data = data;
      row.rcv  = rcv;
      row.typed = typed;
      row.want = '{spare: 1'b0, bad_position: bad, syndrome: syn, parity_count: np,
                   code_length: clen, code_word: cw};
      vectors.push_back(row);
   endfunction

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   // Drain the pipeline, then write the data length register
   task automatic program_length(input logic [5:0] len);
      req_tvalid <= 1'b0;
      while (pending.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= len;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      data_len = len;
   endtask

   // Offer one item, with an optional random gap first, and log its result
   task automatic offer_item(input opcode_type op, input logic [56:0] data,
                             input logic [62:0] rcv, input logic typed,
                             input codec_result_type want);
      if (!sender_quiet && $urandom_range(99) < 37) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 37);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {rcv, data};
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
      pending.push_back(typed ? want : hamming_result(data_len, op, data, rcv));
   endtask

   // Compare each result item with the oldest expectation
   always @(posedge clock) begin : check_results
      codec_result_type want, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %0h", $time, got);
            mismatch_count++;
         end else begin
            want = pending.pop_front();
            check_field("code_word", 64'(want.code_word), 64'(got.code_word));
            check_field("code_length", 64'(want.code_length), 64'(got.code_length));
            check_field("parity_count", 64'(want.parity_count), 64'(got.parity_count));
            check_field("syndrome", 64'(want.syndrome), 64'(got.syndrome));
            check_field("bad_position", 64'(want.bad_position), 64'(got.bad_position));
            check_field("spare", 64'(want.spare), 64'(got.spare));
         end
      end
   end

   // Random ready with one long hold-off and stretches always ready
   initial begin : drive_ready
      int cyc;
      cyc = 0;
      forever begin
         @(posedge clock);
         cyc++;
         if (cyc >= 2000 && cyc < 2300) rsp_tready <= 1'b0;
         else if (sender_quiet || (cyc >= 4000 && cyc < 5500)) rsp_tready <= 1'b1;
         else rsp_tready <= ($urandom_range(99) >= 37);
      end
   end

   initial begin : watchdog
      #(5_000_000);
      $display("simulation failed");
      $finish;
   end

   initial begin : stimulus
      logic [5:0]       phase_lens[12];
      logic [5:0]       len;
      logic [62:0]      rcv;
      logic [56:0]      data;
      codec_result_type enc;
      opcode_type       op;
      int               pick, flip, n;

      phase_lens = '{6'd1, 6'd57, 6'd0, 6'd63, 6'd2, 6'd3, 6'd58, 6'd26,
                     6'd11, 6'd31, 6'd32, 6'd4};

      // after reset: four data bits, seven code bits
      add_vector(6'd4, OP_ENCODE, '0, '0, 1, '0, 6'd7, 3'd3, 6'd0, 1'b0);
      add_vector(6'd4, OP_ENCODE, '1, '0, 1, 63'h7F, 6'd7, 3'd3, 6'd0, 1'b0);
      add_vector(6'd4, OP_CORRECT, '1, 63'h7F, 1, 63'h7F, 6'd7, 3'd3, 6'd0, 1'b0);
      add_vector(6'd4, OP_CORRECT, '0, '1, 1, 63'h7F, 6'd7, 3'd3, 6'd0, 1'b0);
      add_vector(6'd4, OP_CORRECT, '0, 63'h7E, 1, 63'h7F, 6'd7, 3'd3, 6'd1, 1'b0);
      add_vector(6'd4, OP_CORRECT, '1, '0, 1, '0, 6'd7, 3'd3, 6'd0, 1'b0);
      // syndrome past the end of the code
      add_vector(6'd5, OP_CORRECT, '0, 63'h82, 1, 63'h82, 6'd9, 3'd4, 6'd10, 1'b1);
      add_vector(6'd5, OP_ENCODE, 57'(rand64()), 63'(rand64()), 0, '0, '0, '0, '0, 1'b0);
      add_vector(6'd6, OP_CORRECT, '0, 63'h8B, 1, 63'h8B, 6'd10, 3'd4, 6'd15, 1'b1);
      // shortest code, and zero length acting as one
      add_vector(6'd1, OP_ENCODE, '1, '0, 1, 63'h7, 6'd3, 3'd2, 6'd0, 1'b0);
      add_vector(6'd1, OP_CORRECT, '0, 63'h4, 1, '0, 6'd3, 3'd2, 6'd3, 1'b0);
      add_vector(6'd0, OP_ENCODE, 57'h1, '0, 1, 63'h7, 6'd3, 3'd2, 6'd0, 1'b0);
      // longest code
      add_vector(6'd57, OP_ENCODE, '1, '0, 1, '1, 6'd63, 3'd6, 6'd0, 1'b0);
      add_vector(6'd57, OP_CORRECT, '0, '1, 1, '1, 6'd63, 3'd6, 6'd0, 1'b0);
      add_vector(6'd57, OP_CORRECT, '0, {1'b0, {62{1'b1}}}, 1, '1, 6'd63, 3'd6,
                 6'd63, 1'b0);
      add_vector(6'd57, OP_CORRECT, '0, {1'b1, 62'd0}, 1, '0, 6'd63, 3'd6, 6'd63, 1'b0);
      add_vector(6'd57, OP_ENCODE, '0, '1, 1, '0, 6'd63, 3'd6, 6'd0, 1'b0);
      // oversized lengths saturate
      add_vector(6'd63, OP_ENCODE, '1, '0, 1, '1, 6'd63, 3'd6, 6'd0, 1'b0);
      add_vector(6'd58, OP_CORRECT, '0, 63'h1, 1, '0, 6'd63, 3'd6, 6'd1, 1'b0);
      add_vector(6'd11, OP_ENCODE, 57'(rand64()), 63'(rand64()), 0, '0, '0, '0, '0, 1'b0);
      add_vector(6'd11, OP_CORRECT, 57'(rand64()), 63'(rand64()), 0, '0, '0, '0, '0, 1'b0);
      add_vector(6'd26, OP_ENCODE, '1, '0, 0, '0, '0, '0, '0, 1'b0);
      add_vector(6'd2, OP_ENCODE, 57'(rand64()), 63'(rand64()), 0, '0, '0, '0, '0, 1'b0);
      add_vector(6'd3, OP_CORRECT, 57'(rand64()), 63'(rand64()), 0, '0, '0, '0, '0, 1'b0);
      add_vector(6'd32, OP_ENCODE, 57'(rand64()), 63'(rand64()), 0, '0, '0, '0, '0, 1'b0);

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // walk the directed table
      foreach (vectors[v]) begin
         if (vectors[v].len != data_len) program_length(vectors[v].len);
         offer_item(vectors[v].op, vectors[v].data, vectors[v].rcv, vectors[v].typed,
                    vectors[v].want);
      end

      // random phases, one data length each
      n = 0;
      for (int ph = 0; ph < 16; ph++) begin
         len = (ph < 12) ? phase_lens[ph] : 6'($urandom_range(63));
         program_length(len);
         for (int it = 0; it < 100; it++) begin
            sender_quiet = (n >= 700 && n < 1000);
            data = 57'(rand64());
            rcv  = 63'(rand64());
            pick = $urandom_range(99);
            if (pick < 35) begin
               op = OP_ENCODE;
            end else if (pick < 80) begin
               // valid codeword with at most one flipped bit, sometimes tail noise
               op = OP_CORRECT;
               enc = hamming_result(data_len, OP_ENCODE, 57'(rand64()), '0);
               flip = $urandom_range(int'(enc.code_length));
               if (flip != 0) enc.code_word[flip-1] = ~enc.code_word[flip-1];
               if ($urandom_range(3) == 0) begin
                  rcv = enc.code_word | ((rcv >> enc.code_length) << enc.code_length);
               end else begin
                  rcv = enc.code_word;
               end
            end else begin
               op = OP_CORRECT;
            end
            offer_item(op, data, rcv, 1'b0, '0);
            n++;
         end
      end
      sender_quiet = 1'b0;
      req_tvalid <= 1'b0;

      // drain and finish
      while (pending.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+rtl
rtl/hec_pkg.sv
rtl/hamming_encode_correct.sv
tb/sv/tb_hamming_encode_correct.sv
